// ===== sv/tmrg_pkg.sv =====
// Shared types, constants and the control store for the table mixing generator.
// Depends on nothing; the core, the sequencer and the datapath import it.
package tmrg_pkg;

    localparam int unsigned UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;

    localparam logic [31:0] GOLDEN_STEP = 32'h9e37_79b9;
    localparam int unsigned SHL_ODD    = 13;
    localparam int unsigned SHR_EVEN   = 6;
    localparam int unsigned T_RD_SHIFT = 2;
    localparam int unsigned T_WR_SHIFT = 10;
    localparam int unsigned Y_RD_SHIFT = 16;

    typedef enum logic [1:0] {RA_IDX, RA_T, RA_Y} t_ra_sel;
    typedef enum logic {WA_IDX, WA_T} t_wa_sel;
    typedef enum logic [1:0] {WD_ZERO, WD_ACC, WD_Y, WD_MIX} t_wd_sel;
    typedef enum logic [1:0] {JMP_NONE, JMP_ALWAYS, JMP_LOOP} t_jmp;

    // Control store addresses.
    localparam t_upc U_CLEAR      = 4'd0;
    localparam t_upc U_IDLE       = 4'd1;
    localparam t_upc U_RESEED     = 4'd2;
    localparam t_upc U_RESEED_END = 4'd3;
    localparam t_upc U_D0         = 4'd4;
    localparam t_upc U_D1         = 4'd5;
    localparam t_upc U_D2         = 4'd6;
    localparam t_upc U_D3         = 4'd7;
    localparam t_upc U_D4         = 4'd8;
    localparam t_upc U_D5         = 4'd9;
    localparam t_upc U_EMIT       = 4'd10;

    typedef struct packed {
        logic    halt;
        logic    emit;
        t_ra_sel ra_sel;
        logic    wr_en;
        t_wa_sel wa_sel;
        t_wd_sel wd_sel;
        logic    ld_rt;
        logic    ld_y;
        logic    acc_step;
        logic    inc_idx;
        t_jmp    jmp;
        t_upc    target;
    } t_ctrl;

    typedef struct packed {
        logic idx_last;
        logic idx_zero;
    } t_status;

    // One control word per step. Unused addresses fall back to idle.
    function automatic t_ctrl ucode(input t_upc addr);
        t_ctrl c;
        c = '0;
        case (addr)
            U_CLEAR: begin
                c.wr_en   = 1'b1;
                c.wd_sel  = WD_ZERO;
                c.inc_idx = 1'b1;
                c.jmp     = JMP_LOOP;
                c.target  = U_CLEAR;
            end
            U_IDLE: begin
                c.halt = 1'b1;
            end
            U_RESEED: begin
                c.wr_en    = 1'b1;
                c.wd_sel   = WD_ACC;
                c.acc_step = 1'b1;
                c.inc_idx  = 1'b1;
                c.jmp      = JMP_LOOP;
                c.target   = U_RESEED;
            end
            U_RESEED_END: begin
                c.jmp    = JMP_ALWAYS;
                c.target = U_IDLE;
            end
            U_D0: begin
                c.ra_sel = RA_IDX;
            end
            U_D1: begin
                c.ld_rt = 1'b1;
            end
            U_D2: begin
                c.ra_sel = RA_T;
            end
            U_D3: begin
                c.wr_en  = 1'b1;
                c.wa_sel = WA_IDX;
                c.wd_sel = WD_Y;
                c.ld_y   = 1'b1;
            end
            U_D4: begin
                c.ra_sel = RA_Y;
            end
            U_D5: begin
                c.wr_en   = 1'b1;
                c.wa_sel  = WA_T;
                c.wd_sel  = WD_MIX;
                c.inc_idx = 1'b1;
                c.jmp     = JMP_LOOP;
                c.target  = U_D0;
            end
            U_EMIT: begin
                c.emit   = 1'b1;
                c.jmp    = JMP_ALWAYS;
                c.target = U_IDLE;
            end
            default: begin
                c.jmp    = JMP_ALWAYS;
                c.target = U_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== sv/tmrg_if.sv =====
// Valid/ready channel interfaces for the command and random word items.
// Depends on nothing.
interface tmrg_cmd_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] seed;

    modport source (output valid, output operation, output seed, input ready);
    modport sink (input valid, input operation, input seed, output ready);
endinterface

interface tmrg_rnd_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink (input valid, input random_word, output ready);
endinterface

// ===== sv/table_mixing_random_generator_core.sv =====
// Top level of the table mixing random generator: sequencer, datapath, result register.
// Depends on tmrg_pkg, tmrg_if, tmrg_useq and tmrg_datapath.
//
// Channel  Dir  Payload                       Moves
// i_cmd    in   operation (1b), seed (32b)    one reseed or draw request per item
// o_rnd    out  random_word (32b)             one item per draw, none per reseed
//
// A clearing pass after reset zeroes every table word; no item is accepted during it.
// Six control steps per table word, bounded by the single table write port and the
// chain of dependent indirect reads, set the draw time.
// A finished result waits in the output register; the next item is accepted meanwhile,
// and a later draw holds at its final step only if that result is still not taken.
// TABLE_WORDS must be a power of two so that index wrap is a bit select.
module table_mixing_random_generator_core
    import tmrg_pkg::*;
#(
    parameter int unsigned TABLE_WORDS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tmrg_cmd_if.sink     i_cmd,
    tmrg_rnd_if.source   o_rnd
);

    t_ctrl       w_ctrl;
    t_status     w_status;
    logic [31:0] w_result;
    logic        w_start;
    logic        w_out_full;

    logic        r_out_valid;
    logic [31:0] r_out_word;

    // The sequencer only listens for a new item while it sits on its idle step.
    assign i_cmd.ready = w_ctrl.halt;
    assign w_start     = i_cmd.valid && i_cmd.ready;

    // The result slot counts as free when its item leaves in this same cycle.
    assign w_out_full = r_out_valid && !o_rnd.ready;

    tmrg_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_draw     (i_cmd.operation),
        .i_out_full (w_out_full),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    tmrg_datapath #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_start  (w_start),
        .i_seed   (i_cmd.seed),
        .o_status (w_status),
        .o_result (w_result)
    );

    // Output register: loaded by the emit step, emptied when the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rnd.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.emit) begin
            r_out_word <= w_result;
        end
    end

    assign o_rnd.valid       = r_out_valid;
    assign o_rnd.random_word = r_out_word;

    // A new result must never overwrite one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.emit |-> !(r_out_valid && !o_rnd.ready))
        else $error("result register overwritten while occupied");

    // Every table loop must end with the index back at zero.
    a_idx_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.halt |-> w_status.idx_zero)
        else $error("index not at zero while idle");

    // Once an item is taken the sequencer leaves its idle step.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !i_cmd.ready)
        else $error("sequencer still idle after accepting an item");

endmodule

// ===== sv/tmrg_useq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on tmrg_pkg.
module tmrg_useq
    import tmrg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_draw,
    input  logic    i_out_full,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_upc  r_upc;
    t_upc  n_upc;
    t_ctrl w_word;
    logic  w_stall;

    assign w_word  = ucode(r_upc);
    assign w_stall = w_word.emit && i_out_full;

    // While the result slot is occupied the emit step waits and does nothing.
    always_comb begin
        o_ctrl = w_word;
        if (w_stall) begin
            o_ctrl.emit = 1'b0;
        end
    end

    always_comb begin
        n_upc = r_upc;
        if (w_word.halt) begin
            if (i_start) begin
                n_upc = i_draw ? U_D0 : U_RESEED;
            end
        end else if (!w_stall) begin
            case (w_word.jmp)
                JMP_NONE:   n_upc = r_upc + 1'b1;
                JMP_ALWAYS: n_upc = w_word.target;
                JMP_LOOP:   n_upc = i_status.idx_last ? r_upc + 1'b1 : w_word.target;
                default:    n_upc = U_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_CLEAR;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== sv/tmrg_datapath.sv =====
// Datapath: the mixing table memory, index counter, running result and temporaries.
// Depends on tmrg_pkg; driven by the control word of tmrg_useq.
module tmrg_datapath
    import tmrg_pkg::*;
#(
    parameter int unsigned TABLE_WORDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    input  logic        i_start,
    input  logic [31:0] i_seed,
    output t_status     o_status,
    output logic [31:0] o_result
);

    localparam int unsigned IDX_W = $clog2(TABLE_WORDS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_WORDS - 1);
    localparam logic [IDX_W-1:0] IDX_HALF = IDX_W'(TABLE_WORDS / 2);

    logic [31:0]      r_mem [TABLE_WORDS];
    logic [31:0]      r_rd_a;
    logic [31:0]      r_rd_b;
    logic [IDX_W-1:0] r_idx;
    logic [31:0]      r_res;
    logic [31:0]      r_t;
    logic [31:0]      r_y;
    logic [31:0]      r_acc;

    logic [IDX_W-1:0] w_raddr_a;
    logic [IDX_W-1:0] w_raddr_b;
    logic [IDX_W-1:0] w_waddr;
    logic [31:0]      w_wdata;
    logic [31:0]      w_y_sum;
    logic [31:0]      w_res_mix;
    logic [31:0]      w_t_sum;

    assign o_status.idx_last = (r_idx == IDX_LAST);
    assign o_status.idx_zero = (r_idx == '0);
    assign o_result          = r_res;

    assign w_y_sum   = r_rd_a + r_t;
    assign w_res_mix = (r_idx[0] ? (r_res ^ (r_res << SHL_ODD))
                                 : (r_res ^ (r_res >> SHR_EVEN))) ^ r_rd_a;
    assign w_t_sum   = r_rd_b + w_res_mix;
    assign w_raddr_b = r_idx + IDX_HALF;

    always_comb begin
        case (i_ctrl.ra_sel)
            RA_IDX:  w_raddr_a = r_idx;
            RA_T:    w_raddr_a = r_t[T_RD_SHIFT +: IDX_W];
            RA_Y:    w_raddr_a = r_y[Y_RD_SHIFT +: IDX_W];
            default: w_raddr_a = r_idx;
        endcase
    end

    always_comb begin
        case (i_ctrl.wa_sel)
            WA_IDX:  w_waddr = r_idx;
            WA_T:    w_waddr = r_t[T_WR_SHIFT +: IDX_W];
            default: w_waddr = r_idx;
        endcase
    end

    always_comb begin
        case (i_ctrl.wd_sel)
            WD_ZERO: w_wdata = '0;
            WD_ACC:  w_wdata = r_acc;
            WD_Y:    w_wdata = w_y_sum;
            WD_MIX:  w_wdata = r_rd_a + {r_t[30:0], 1'b0};
            default: w_wdata = '0;
        endcase
    end

    // Table memory: one write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= r_mem[w_raddr_a];
        r_rd_b <= r_mem[w_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_res <= '0;
        end else begin
            if (i_ctrl.inc_idx) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_ctrl.ld_rt) begin
                r_res <= w_res_mix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_rt) begin
            r_t <= w_t_sum;
        end
        if (i_ctrl.ld_y) begin
            r_y <= w_y_sum;
        end
        if (i_start) begin
            r_acc <= i_seed;
        end else if (i_ctrl.acc_step) begin
            r_acc <= r_acc + GOLDEN_STEP;
        end
    end

endmodule

// ===== tb/sv/tmrg_tb_pkg.sv =====
`timescale 1ns / 100ps
// Command codes and table size shared by the generator testbench files.
// Depends on nothing; the checker and the testbench top import it.
package tmrg_tb_pkg;

    typedef enum logic {
        OP_RESEED = 1'b0,
        OP_DRAW   = 1'b1
    } t_tb_op;

    localparam int unsigned TB_TABLE_WORDS = 256;

endpackage

// ===== tb/sv/tmrg_result_checker.sv =====
`timescale 1ns / 100ps
// Watches the command and random word channels, predicts every draw and compares.
// Depends on tmrg_tb_pkg and the channel interfaces in tmrg_if.
module tmrg_result_checker
    import tmrg_tb_pkg::*;
#(
    parameter int unsigned TABLE_WORDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmrg_cmd_if         i_cmd,
    tmrg_rnd_if         i_rnd,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    localparam logic [31:0] SEED_INC = 32'h9e37_79b9;

    logic [31:0] mix_words [TABLE_WORDS];
    logic [31:0] mix_acc;
    logic [31:0] expected_words [$];
    int unsigned fail_total;

    function automatic int unsigned wrap_idx(input logic [31:0] v);
        return v % TABLE_WORDS;
    endfunction

    task automatic fill_from_seed(input logic [31:0] seed);
        logic [31:0] w;
        w = seed;
        for (int unsigned k = 0; k < TABLE_WORDS; k++) begin
            mix_words[k] = w;
            w = w + SEED_INC;
        end
    endtask

    // One full pass over the table; every indirect read sees all earlier writes.
    task automatic mix_pass(output logic [31:0] word);
        logic [31:0] x;
        logic [31:0] t;
        logic [31:0] y;
        for (int unsigned i = 0; i < TABLE_WORDS; i++) begin
            x = mix_words[i];
            if (i % 2 == 1)
                mix_acc = mix_acc ^ (mix_acc << 13);
            else
                mix_acc = mix_acc ^ (mix_acc >> 6);
            mix_acc = mix_acc ^ x;
            t = mix_words[wrap_idx(i + TABLE_WORDS / 2)] + mix_acc;
            y = mix_words[wrap_idx(t >> 2)] + t;
            mix_words[i] = y;
            mix_words[wrap_idx(t >> 10)] = mix_words[wrap_idx(y >> 16)] + (t << 1);
        end
        word = mix_acc;
    endtask

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            for (int unsigned k = 0; k < TABLE_WORDS; k++)
                mix_words[k] = '0;
            mix_acc = '0;
            expected_words.delete();
            fail_total = 0;
        end else begin
            if (i_rnd.valid && i_rnd.ready) begin
                if (expected_words.size() == 0) begin
                    $error("random_word arrived with no draw outstanding: actual %h",
                           i_rnd.random_word);
                    fail_total++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_rnd.random_word !== want) begin
                        $error("random_word mismatch: expected %h, actual %h",
                               want, i_rnd.random_word);
                        fail_total++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                if (i_cmd.operation == OP_DRAW) begin
                    mix_pass(want);
                    expected_words.push_back(want);
                end else begin
                    fill_from_seed(i_cmd.seed);
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_words.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the table mixing random generator: clock, reset, stimulus, verdict.
// Depends on tmrg_pkg, tmrg_if, tmrg_tb_pkg, tmrg_result_checker and the generator core.
module tb;
    import tmrg_tb_pkg::*;

    localparam int unsigned TABLE_WORDS  = TB_TABLE_WORDS;
    // A draw runs six steps per table word, then its emit step.
    localparam int unsigned DRAW_CYCLES  = 6 * TABLE_WORDS + 2;
    // Worst case: every item a draw, each result held back by a receiver stall,
    // plus the clearing pass after reset and the long hold-off; then margin.
    localparam int unsigned LIMIT_CYCLES = 3_000_000;
    localparam int unsigned DRAIN_CYCLES = 2 * DRAW_CYCLES;
    localparam int unsigned RANDOM_ITEMS = 375;
    localparam int unsigned IDLE_PCT     = 18;
    localparam int unsigned DRAW_PCT     = 60;

    // The receiver stops taking results for a long time at this point so that a
    // finished word sits in the output register, the next draw stalls at its last
    // step and the command channel backs up while the sender keeps offering items.
    localparam int unsigned HOLD_START   = 30_000;
    localparam int unsigned HOLD_CYCLES  = 6_000;
    // Window of receiver cycles in which the receiver never stalls.
    localparam int unsigned RX_STEADY_LO = 150_000;
    localparam int unsigned RX_STEADY_HI = 250_000;
    // Window of random items that the sender offers back to back.
    localparam int unsigned TX_STEADY_LO = 150;
    localparam int unsigned TX_STEADY_HI = 230;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned fail_count;
    int unsigned pending_draws;
    int unsigned cycle_count;
    bit          tx_steady;

    tmrg_cmd_if cmd_ch ();
    tmrg_rnd_if rnd_ch ();

    table_mixing_random_generator_core #(
        .TABLE_WORDS(TABLE_WORDS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rnd   (rnd_ch)
    );

    tmrg_result_checker #(
        .TABLE_WORDS(TABLE_WORDS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_rnd        (rnd_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_draws)
    );

    // 4 ns period: two ns low, two ns high.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Global watchdog. A hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one item and holds it until the core takes it. Afterwards the sender
    // may idle for a few cycles, each cycle with a small chance, so that gaps land
    // on every phase of a reseed or a draw. While idle the payload carries junk.
    task automatic send_item(input t_tb_op op, input logic [31:0] seed);
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.seed      <= seed;
        @(posedge i_clk);
        while (!cmd_ch.ready)
            @(posedge i_clk);
        if (!tx_steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                cmd_ch.valid     <= 1'b0;
                cmd_ch.operation <= t_tb_op'($urandom_range(1));
                cmd_ch.seed      <= $urandom;
                @(posedge i_clk);
            end
        end
    endtask

    // Receiver: random stalls, one long hold-off and one stretch without stalls.
    // Its own cycle count drives the hold-off so it does not depend on the sender.
    initial begin
        int unsigned rx_cycles;
        int unsigned hold_left;
        rx_cycles = 0;
        hold_left = 0;
        rnd_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycles++;
            if (rx_cycles == HOLD_START)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                rnd_ch.ready <= 1'b0;
            end else if (rx_cycles >= RX_STEADY_LO && rx_cycles < RX_STEADY_HI) begin
                rnd_ch.ready <= 1'b1;
            end else begin
                rnd_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        t_tb_op op;
        tx_steady        = 1'b0;
        i_rst_n          <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.operation <= OP_RESEED;
        cmd_ch.seed      <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The first two draws mix the all-zero table left by reset.
        send_item(OP_DRAW, 32'h0000_0000);
        send_item(OP_DRAW, 32'hffff_ffff);
        // Seed extremes; a reseed keeps the running result, so draws continue from it.
        send_item(OP_RESEED, 32'h0000_0000);
        send_item(OP_DRAW, 32'h0000_0000);
        send_item(OP_RESEED, 32'hffff_ffff);
        send_item(OP_DRAW, 32'hffff_ffff);
        send_item(OP_DRAW, 32'h5555_5555);
        // Back-to-back reseeds: only the last one should count.
        send_item(OP_RESEED, 32'h8000_0000);
        send_item(OP_RESEED, 32'h0000_0001);
        send_item(OP_DRAW, 32'haaaa_aaaa);
        // This seed makes word one zero; the golden step itself makes word zero odd.
        send_item(OP_RESEED, 32'h61c8_8647);
        send_item(OP_DRAW, 32'h0000_0000);
        send_item(OP_RESEED, 32'h9e37_79b9);
        send_item(OP_DRAW, 32'h7fff_ffff);
        send_item(OP_RESEED, 32'h7fff_ffff);
        send_item(OP_DRAW, 32'h8000_0000);
        send_item(OP_DRAW, 32'h0000_0001);
        send_item(OP_RESEED, 32'haaaa_aaaa);
        send_item(OP_RESEED, 32'h5555_5555);
        send_item(OP_DRAW, 32'hffff_ffff);

        // Random part: draws dominate, reseeds keep the table content fresh.
        // Seeds on draws are random too, since the core must ignore them.
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            tx_steady = (n >= TX_STEADY_LO && n < TX_STEADY_HI);
            op = ($urandom_range(99) < DRAW_PCT) ? OP_DRAW : OP_RESEED;
            send_item(op, $urandom);
        end
        tx_steady = 1'b0;
        cmd_ch.valid <= 1'b0;

        // Let the checker see the last accepted item before looking at its count.
        @(posedge i_clk);
        while (pending_draws != 0)
            @(posedge i_clk);
        // Any stray extra result would show up in this window.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_draws == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tmrg_pkg.sv
sv/tmrg_if.sv
sv/tmrg_useq.sv
sv/tmrg_datapath.sv
sv/table_mixing_random_generator_core.sv
tb/sv/tmrg_tb_pkg.sv
tb/sv/tmrg_result_checker.sv
tb/sv/tb.sv
